>>> design/vmfs_pkg.sv
// Shared types and constants for the virtual machine frame stack.
package vmfs_pkg;

  localparam int unsigned Depth     = 1024;
  localparam int unsigned WordW     = 32;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CountW    = 11;
  localparam int unsigned FillW     = 11;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned TopW      = $clog2(Depth + 1);
  localparam int unsigned CmpW      = ((TopW > CountW) ? TopW : CountW) + 1;

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_GROW   = 3'd2,
    KIND_SHRINK = 3'd3,
    KIND_LOAD   = 3'd4,
    KIND_STORE  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNDER  = 2'd1,
    ST_OVER   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [WordW-1:0] value;
    logic [IdxW-1:0]         slot_index;
    logic [CountW-1:0]       slot_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WordW-1:0] read_word;
    logic [FillW-1:0]        fill_level;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic             use_rd;
    logic [FillW-1:0] fill_level;
  } res_info_t;

endpackage

>>> design/vm_frame_stack.sv
// Top level of the virtual machine data stack: control, word store and result assembly.
//
//   Channel | Direction | Handshake                 | Item
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | kind, value, slot_index, slot_count
//   out     | output    | out_valid_o / out_stall_i | status, read_word, fill_level
//
// Each item passes through the control stage and shows up as a result
// on the next cycle; with the output taken every cycle, one item is accepted
// per cycle. The single-port word store carries at most one access per item,
// so a push or store is written at acceptance and a pop or load is read in the
// same cycle, its registered data arriving together with the result.
// After reset a clearing sweep writes zero into all 1024 entries, one per
// cycle; while it runs in_stall_o stays high.
// While a result waits under out_stall_i, no new item is accepted, so the
// read data held by the store's output register stays put.
module vm_frame_stack import vmfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  mem_req_t         mem_req;
  res_info_t        res;
  logic [WordW-1:0] rdata;

  // Decode, depth bookkeeping, the clearing sweep and the result register.
  vmfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .mem_req_o   (mem_req),
    .res_o       (res)
  );

  // The word store itself.
  vmfs_ram #(
    .Width (WordW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // Read data is reported only for a successful pop or load; everything else
  // returns zero.
  assign out_valid_o           = res.valid;
  assign out_item_o.status     = res.status;
  assign out_item_o.read_word  = res.use_rd ? rdata : '0;
  assign out_item_o.fill_level = res.fill_level;

endmodule

>>> design/vmfs_ram.sv
// Single-port synchronous RAM with a registered read port.
module vmfs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/vmfs_ctrl.sv
// Request decode, depth tracking, clearing sweep and result register of the stack.
module vmfs_ctrl import vmfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  logic      out_stall_i,
  output mem_req_t  mem_req_o,
  output res_info_t res_o
);

  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [TopW-1:0]  top_q, top_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic             use_rd_q, use_rd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             in_accept;
  logic [CmpW-1:0]  top_ext, cnt_ext, idx_ext, room_ext;
  mem_req_t         mem_req;

  assign in_stall_o = clr_q | (out_valid_q & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign top_ext  = CmpW'(top_q);
  assign cnt_ext  = CmpW'(in_item_i.slot_count);
  assign idx_ext  = CmpW'(in_item_i.slot_index);
  assign room_ext = CmpW'(Depth) - top_ext;

  always_comb begin
    top_d       = top_q;
    status_d    = status_q;
    use_rd_d    = use_rd_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q & out_stall_i;
    mem_req     = '0;

    if (clr_q) begin
      // Zero one entry a cycle until the whole store is clean.
      mem_req.en  = 1'b1;
      mem_req.we  = 1'b1;
      mem_req.addr = clr_addr_q;
      clr_addr_d  = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_d = 1'b0;
      end
    end else if (in_accept) begin
      status_d    = ST_OK;
      use_rd_d    = 1'b0;
      out_valid_d = 1'b1;
      case (kind_e'(in_item_i.kind))
        KIND_PUSH: begin
          if (top_ext >= CmpW'(Depth)) begin
            status_d = ST_OVER;
          end else begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = AddrW'(top_q);
            mem_req.wdata = in_item_i.value;
            top_d         = top_q + TopW'(1);
          end
        end
        KIND_POP: begin
          if (top_q == '0) begin
            status_d = ST_UNDER;
          end else begin
            mem_req.en   = 1'b1;
            mem_req.addr = AddrW'(top_q - TopW'(1));
            use_rd_d     = 1'b1;
            top_d        = top_q - TopW'(1);
          end
        end
        KIND_GROW: begin
          if (cnt_ext > room_ext) begin
            status_d = ST_OVER;
          end else begin
            top_d = TopW'(top_ext + cnt_ext);
          end
        end
        KIND_SHRINK: begin
          if (cnt_ext > top_ext) begin
            status_d = ST_UNDER;
          end else begin
            top_d = TopW'(top_ext - cnt_ext);
          end
        end
        KIND_LOAD: begin
          if (idx_ext >= top_ext) begin
            status_d = ST_BADIDX;
          end else begin
            mem_req.en   = 1'b1;
            mem_req.addr = AddrW'(in_item_i.slot_index);
            use_rd_d     = 1'b1;
          end
        end
        KIND_STORE: begin
          if (idx_ext >= top_ext) begin
            status_d = ST_BADIDX;
          end else begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = AddrW'(in_item_i.slot_index);
            mem_req.wdata = in_item_i.value;
          end
        end
        default: begin
        end
      endcase
      fill_d = FillW'(top_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    use_rd_q <= use_rd_d;
    fill_q   <= fill_d;
  end

  assign mem_req_o        = mem_req;
  assign res_o.valid      = out_valid_q;
  assign res_o.status     = status_q;
  assign res_o.use_rd     = use_rd_q;
  assign res_o.fill_level = fill_q;

`ifndef SYNTHESIS
  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TopW'(Depth))
    else $error("stack depth beyond capacity");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_accept)
    else $error("item accepted during clearing sweep");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (mem_req.en && mem_req.we && mem_req.wdata == '0))
    else $error("clearing sweep does not write zero");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.en && !mem_req.we && !clr_q) |=> (out_valid_q && use_rd_q))
    else $error("memory read without a pending result");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(fill_q) && $stable(status_q)))
    else $error("result changed while stalled");
`endif

endmodule
